// ===== rtl/fba_pkg.sv =====
`timescale 1ns / 1ps
// fba_pkg: constants, codes and a helper function of the frame bitmap allocator.
// No dependencies.
package fba_pkg;

  localparam int FRAME_COUNT = 65536;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = FRAME_COUNT / WORD_BITS;
  localparam int WORD_AW     = $clog2(MAP_WORDS);
  localparam int BIT_AW      = $clog2(WORD_BITS);
  localparam int CNT_W       = WORD_AW + 1;
  localparam int FRAME_W     = 16;
  localparam int CFG_W       = 17;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;

  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;
  localparam logic [CFG_W-1:0] TOTAL_FRAMES_RESET = CFG_W'(65536);

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC_AT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE     = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd2;

  // index of the lowest clear bit; meaningless for a full word
  function automatic logic [BIT_AW-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
    logic [BIT_AW-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_AW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// frame_bitmap_allocator: first-fit physical frame allocator over a bitmap memory.
// Depends on fba_pkg.
//
// The block keeps one bit per physical frame (1 = in use) in a 2048 x 32 synchronous
// memory and serves one request at a time: allocate the lowest free frame, allocate a
// named frame, or free the frame of a page entry; each request returns one page entry
// plus a status. After reset the block first sweeps the memory to zero, one word per
// cycle; in_ready stays low during that sweep, while writes to total_frames are
// taken as ever. Allocate-lowest reads one bitmap word per cycle through the single
// read port and stops at the first non-full word, searching at most
// min(total_frames/32, 2048) words when no frame is free. Allocate-at and free of a
// nonzero frame do a read-modify-write of one word. Everything else (allocate on a
// present entry, free of frame zero, request type 3) goes straight to the result.
// The next request can be taken in the cycle after the result moves to the output
// register, even while the consumer still holds that result off.
module frame_bitmap_allocator (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: total_frames
  input  logic                            cfg_we,
  input  logic [fba_pkg::CFG_W-1:0]       cfg_wdata,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fba_pkg::REQ_W-1:0]       req_type,
  input  logic [fba_pkg::FRAME_W-1:0]     frame_number,
  input  logic                            entry_present,
  input  logic                            entry_rw,
  input  logic                            entry_user,
  input  logic [fba_pkg::FRAME_W-1:0]     entry_frame,
  input  logic                            supervisor,
  input  logic                            grant_write,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fba_pkg::STATUS_W-1:0]    status,
  output logic                            out_present,
  output logic                            out_rw,
  output logic                            out_user,
  output logic [fba_pkg::FRAME_W-1:0]     out_frame
);
  import fba_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_RMW_RD = 3'd3;
  localparam logic [2:0] S_RMW_WR = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [CFG_W-1:0] total_frames;

  // bitmap memory
  logic [WORD_BITS-1:0] bitmap [MAP_WORDS];
  logic                 mem_we;
  logic [WORD_AW-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_AW-1:0]   mem_raddr;
  logic [WORD_BITS-1:0] rdata;

  // clearing sweep
  logic [WORD_AW-1:0] clr_idx;

  // scan pipeline: issue one read per cycle, check the word in the cycle after its read
  logic [CNT_W-1:0]   issue_idx;
  logic [CNT_W-1:0]   scan_words;
  logic               chk_vld;
  logic [WORD_AW-1:0] chk_idx;
  logic               scan_rd;
  logic               chk_hit;
  logic               scan_fail;
  logic [BIT_AW-1:0]  hit_bit;
  logic [CNT_W-1:0]   tf_words;

  // held request
  logic               kern_q;
  logic               wr_q;
  logic               rmw_set;
  logic [FRAME_W-1:0] rmw_frame;
  logic [WORD_BITS-1:0] rmw_mask;

  // result waiting for the output register
  logic [STATUS_W-1:0] res_status;
  logic                res_present;
  logic                res_rw;
  logic                res_user;
  logic [FRAME_W-1:0]  res_frame;

  logic accept;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // words searched: whole words below total_frames, capped at the map size
  assign tf_words   = CNT_W'(total_frames >> BIT_AW);
  assign scan_words = (tf_words > CNT_W'(MAP_WORDS)) ? CNT_W'(MAP_WORDS) : tf_words;

  assign scan_rd   = (state == S_SCAN) && (issue_idx < scan_words);
  assign chk_hit   = (state == S_SCAN) && chk_vld && (rdata != FULL_WORD);
  assign scan_fail = (state == S_SCAN) && !chk_hit && (issue_idx >= scan_words);
  assign hit_bit   = lowest_clear(rdata);
  assign rmw_mask  = WORD_BITS'(1) << rmw_frame[BIT_AW-1:0];

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = '0;
    mem_raddr = issue_idx[WORD_AW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        if (chk_hit) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx;
          mem_wdata = rdata | (WORD_BITS'(1) << hit_bit);
        end
      end
      S_RMW_RD: begin
        mem_raddr = rmw_frame[FRAME_W-1 -: WORD_AW];
      end
      S_RMW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = rmw_frame[FRAME_W-1 -: WORD_AW];
        mem_wdata = rmw_set ? (rdata | rmw_mask) : (rdata & ~rmw_mask);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_waddr] <= mem_wdata;
    end
    rdata <= bitmap[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == WORD_AW'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_ALLOC:    state_next = entry_present ? S_DONE : S_SCAN;
            REQ_ALLOC_AT: state_next = S_RMW_RD;
            REQ_FREE:     state_next = (entry_frame != '0) ? S_RMW_RD : S_DONE;
            default:      state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (chk_hit || scan_fail) begin
          state_next = S_DONE;
        end
      end
      S_RMW_RD: state_next = S_RMW_WR;
      S_RMW_WR: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      total_frames <= TOTAL_FRAMES_RESET;
      out_valid    <= 1'b0;
      chk_vld      <= 1'b0;
      issue_idx    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        total_frames <= cfg_wdata;
      end
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + WORD_AW'(1);
      end
      // advance the scan: chk_vld marks a read issued in the previous cycle
      if (accept) begin
        issue_idx <= '0;
        chk_vld   <= 1'b0;
      end else if (state == S_SCAN) begin
        chk_vld <= scan_rd;
        if (scan_rd) begin
          issue_idx <= issue_idx + CNT_W'(1);
        end
      end
      // hand the result to the output register once it is free
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      chk_idx <= issue_idx[WORD_AW-1:0];
    end
    if (accept) begin
      kern_q    <= supervisor;
      wr_q      <= grant_write;
      rmw_set   <= (req_type == REQ_ALLOC_AT);
      rmw_frame <= (req_type == REQ_ALLOC_AT) ? frame_number : entry_frame;
      // allocate-at builds a fresh entry; everything else starts from the incoming one
      res_status  <= (req_type == REQ_ALLOC && entry_present) ? ST_PRESENT : ST_DONE;
      res_present <= (req_type == REQ_ALLOC_AT) ? 1'b1 : entry_present;
      res_rw      <= (req_type == REQ_ALLOC_AT) ? grant_write : entry_rw;
      res_user    <= (req_type == REQ_ALLOC_AT) ? !supervisor : entry_user;
      res_frame   <= (req_type == REQ_ALLOC_AT) ? frame_number :
                     (req_type == REQ_FREE)     ? '0 : entry_frame;
    end else if (chk_hit) begin
      res_status  <= ST_DONE;
      res_present <= 1'b1;
      res_rw      <= wr_q;
      res_user    <= !kern_q;
      res_frame   <= FRAME_W'({chk_idx, hit_bit});
    end else if (scan_fail) begin
      res_status  <= ST_NO_FRAME;
      res_present <= 1'b0;
      res_rw      <= 1'b0;
      res_user    <= 1'b0;
      res_frame   <= '0;
    end
    if (state == S_DONE && out_free) begin
      status      <= res_status;
      out_present <= res_present;
      out_rw      <= res_rw;
      out_user    <= res_user;
      out_frame   <= res_frame;
    end
  end

  // a scan writes back only a word it actually read and found not full
  a_scan_write_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && mem_we) |-> (chk_vld && rdata != FULL_WORD))
    else $error("scan wrote back a full or unread word");

  // one request at a time: ready drops right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request taken while another is in flight");

  // a failed allocation returns an empty entry
  a_no_frame_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NO_FRAME) |-> (!out_present && !out_rw && !out_user
                                              && out_frame == '0))
    else $error("no-frame result carries a nonempty entry");

endmodule

// ===== dv/frame_bitmap_allocator_test.sv =====
`timescale 1ns / 1ps
// frame_bitmap_allocator_test: self-checking bench for the first-fit frame allocator.
// Depends on fba_pkg and frame_bitmap_allocator. The bench keeps its own bitmap and
// checks each returned page entry.
module frame_bitmap_allocator_test;
  import fba_pkg::*;

  // Type 3 is not decoded by the block. It passes the entry through untouched.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_WAIT     = 11;
  localparam int MAX_SHOWN    = 10;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [FRAME_W-1:0] claim_frame;
    logic               present;
    logic               rw;
    logic               user;
    logic [FRAME_W-1:0] frame;
    logic               kernel;
    logic               writable;
  } frame_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                present;
    logic                rw;
    logic                user;
    logic [FRAME_W-1:0]  frame;
  } page_entry_t;

  // Every block input starts at a known value.
  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                cfg_we        = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata     = '0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [REQ_W-1:0]    req_type      = '0;
  logic [FRAME_W-1:0]  frame_number  = '0;
  logic                entry_present = 1'b0;
  logic                entry_rw      = 1'b0;
  logic                entry_user    = 1'b0;
  logic [FRAME_W-1:0]  entry_frame   = '0;
  logic                supervisor    = 1'b0;
  logic                grant_write   = 1'b0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                out_present;
  logic                out_rw;
  logic                out_user;
  logic [FRAME_W-1:0]  out_frame;

  frame_bitmap_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .frame_number  (frame_number),
    .entry_present (entry_present),
    .entry_rw      (entry_rw),
    .entry_user    (entry_user),
    .entry_frame   (entry_frame),
    .supervisor    (supervisor),
    .grant_write   (grant_write),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .out_present   (out_present),
    .out_rw        (out_rw),
    .out_user      (out_user),
    .out_frame     (out_frame)
  );

  // Bench copy of the allocator state: one bit per frame, 1 = in use.
  logic [WORD_BITS-1:0] frame_in_use [MAP_WORDS];
  logic [CFG_W-1:0]     frames_limit;

  frame_req_t  pending_reqs[$];  // requests waiting for the driver
  page_entry_t entries_due[$];   // page entries the block still owes, oldest first
  frame_req_t  on_bus;           // request currently offered on the input channel
  page_entry_t want_entry;
  page_entry_t seen_entry;

  int  queued      = 0;  // requests queued so far
  int  returned    = 0;  // entries that have come back so far
  int  errors      = 0;
  int  send_wait   = 0;
  int  recv_wait   = 0;
  int  recv_draw   = 0;
  bit  steady      = 1'b0;  // set: neither side idles
  int  kind_count [4];
  int  no_frame_count = 0;
  int  present_count  = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop. The slowest legal run (every allocate scanning all 2048 words,
  // both sides at their longest stall) stays well below this.
  initial begin
    #12_000_000;
    $display("[%0t] timeout with %0d entries still owed", $time, queued - returned);
    $display("** frame_bitmap_allocator: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void put_frame_bit(input logic [FRAME_W-1:0] f, input bit used);
    // A 16-bit frame always lands inside the 65536-frame map.
    frame_in_use[f[FRAME_W-1:BIT_AW]][f[BIT_AW-1:0]] = used;
  endfunction

  // First fit. Scan whole words below the frame limit, skip full ones, and claim the
  // lowest clear bit of the first word with room.
  function automatic bit claim_lowest(output logic [FRAME_W-1:0] frame);
    int words;
    words = frames_limit / WORD_BITS;
    if (words > MAP_WORDS) begin
      words = MAP_WORDS;
    end
    frame = '0;
    for (int w = 0; w < words; w++) begin
      if (frame_in_use[w] != FULL_WORD) begin
        for (int b = 0; b < WORD_BITS; b++) begin
          if (!frame_in_use[w][b]) begin
            frame = FRAME_W'(w * WORD_BITS + b);
            put_frame_bit(frame, 1'b1);
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Work out the page entry that a request returns, and update the bitmap with it.
  function automatic page_entry_t apply_request(input frame_req_t r);
    page_entry_t        e;
    logic [FRAME_W-1:0] found;
    // Start from a pass-through of the incoming entry.
    e.status  = ST_DONE;
    e.present = r.present;
    e.rw      = r.rw;
    e.user    = r.user;
    e.frame   = r.frame;
    case (r.kind)
      REQ_ALLOC: begin
        if (r.present) begin
          e.status = ST_PRESENT;
        end else if (claim_lowest(found)) begin
          e.present = 1'b1;
          e.rw      = r.writable;
          e.user    = !r.kernel;
          e.frame   = found;
        end else begin
          // No room: every entry bit reads zero.
          e        = '0;
          e.status = ST_NO_FRAME;
        end
      end
      REQ_ALLOC_AT: begin
        // Claimed even if already in use and whatever the frame limit is.
        put_frame_bit(r.claim_frame, 1'b1);
        e.present = 1'b1;
        e.rw      = r.writable;
        e.user    = !r.kernel;
        e.frame   = r.claim_frame;
      end
      REQ_FREE: begin
        // Frame zero is never released.
        if (r.frame != '0) begin
          put_frame_bit(r.frame, 1'b0);
          e.frame = '0;
        end
      end
      default: begin
      end
    endcase
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic frame_req_t make_request(
    input logic [REQ_W-1:0] kind, input logic [FRAME_W-1:0] claim_frame,
    input bit present, input bit rw, input bit user, input logic [FRAME_W-1:0] frame,
    input bit kernel, input bit writable);
    frame_req_t r;
    r.kind        = kind;
    r.claim_frame = claim_frame;
    r.present     = present;
    r.rw          = rw;
    r.user        = user;
    r.frame       = frame;
    r.kernel      = kernel;
    r.writable    = writable;
    return r;
  endfunction

  // Mostly frames in the working range (so frees hit frames in use), plus the
  // extremes and full 16-bit noise.
  function automatic logic [FRAME_W-1:0] pick_frame(input int span);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return '0;
    end
    if (pick == 1) begin
      return '1;
    end
    if (pick == 2) begin
      return FRAME_W'($urandom);
    end
    return FRAME_W'($urandom_range(0, span - 1));
  endfunction

  function automatic frame_req_t random_request(input int span);
    frame_req_t r;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.kind = REQ_ALLOC;
    end else if (pick < 65) begin
      r.kind = REQ_ALLOC_AT;
    end else if (pick < 95) begin
      r.kind = REQ_FREE;
    end else begin
      r.kind = REQ_UNUSED;
    end
    r.claim_frame = pick_frame(span);
    r.frame       = pick_frame(span);
    // Keep most allocates on empty entries so that they actually search.
    if (r.kind == REQ_ALLOC) begin
      r.present = ($urandom_range(0, 6) == 0);
    end else begin
      r.present = ($urandom_range(0, 1) == 1);
    end
    r.rw       = ($urandom_range(0, 1) == 1);
    r.user     = ($urandom_range(0, 1) == 1);
    r.kernel   = ($urandom_range(0, 1) == 1);
    r.writable = ($urandom_range(0, 1) == 1);
    return r;
  endfunction

  task automatic queue_request(input frame_req_t r);
    pending_reqs.push_back(r);
    kind_count[r.kind]++;
    queued++;
  endtask

  // Hold the sender until every owed entry has come back.
  task automatic wait_drained();
    while (returned != queued) begin
      @(posedge clk);
    end
  endtask

  // No request is in flight here, so the new limit applies to everything queued after.
  task automatic set_total_frames(input logic [CFG_W-1:0] limit);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    frames_limit = limit;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] limit, input int count, input int span,
                           input bit no_gaps);
    wait_drained();
    set_total_frames(limit);
    steady = no_gaps;
    repeat (count) begin
      queue_request(random_request(span));
    end
  endtask

  task automatic flag(input string why, input page_entry_t want, input page_entry_t seen);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("[%0t] %s: expected st %0d p %0d rw %0d u %0d frame %0d",
               $time, why, want.status, want.present, want.rw, want.user, want.frame);
      $display("    got st %0d p %0d rw %0d u %0d frame %0d",
               seen.status, seen.present, seen.rw, seen.user, seen.frame);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: offer queued requests, each followed by a random gap before the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
      for (int w = 0; w < MAP_WORDS; w++) begin
        frame_in_use[w] = '0;
      end
    end else begin
      // Predict at the transfer, in the order the block sees the requests.
      if (in_valid && in_ready) begin
        entries_due.push_back(apply_request(on_bus));
      end
      // The slot is free once the current request has moved, or nothing was offered.
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          in_valid  <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          on_bus = pending_reqs.pop_front();
          req_type      <= on_bus.kind;
          frame_number  <= on_bus.claim_frame;
          entry_present <= on_bus.present;
          entry_rw      <= on_bus.rw;
          entry_user    <= on_bus.user;
          entry_frame   <= on_bus.frame;
          supervisor    <= on_bus.kernel;
          grant_write   <= on_bus.writable;
          in_valid      <= 1'b1;
          send_wait     <= draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check each transfer against the oldest owed entry, and drop
  // ready for a random stretch after each one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_entry.status  = status;
        seen_entry.present = out_present;
        seen_entry.rw      = out_rw;
        seen_entry.user    = out_user;
        seen_entry.frame   = out_frame;
        if (entries_due.size() == 0) begin
          flag("entry with nothing owed", '0, seen_entry);
        end else begin
          want_entry = entries_due.pop_front();
          returned++;
          if (want_entry.status == ST_NO_FRAME) begin
            no_frame_count++;
          end
          if (want_entry.status == ST_PRESENT) begin
            present_count++;
          end
          if (seen_entry !== want_entry) begin
            flag("entry mismatch", want_entry, seen_entry);
          end
        end
        recv_draw = draw_wait();
        recv_wait <= recv_draw;
        out_ready <= (recv_draw == 0) ? 1'b1 : 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_ready <= (recv_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed checks, then random phases over several frame limits
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < 4; k++) begin
      kind_count[k] = 0;
    end
    frames_limit = TOTAL_FRAMES_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the full map.
    set_total_frames(CFG_W'(65536));
    // lowest free from an empty map, user writable then supervisor read-only
    queue_request(make_request(REQ_ALLOC, 16'hffff, 0, 0, 0, 16'h0000, 0, 1));
    queue_request(make_request(REQ_ALLOC, 16'h0000, 0, 1, 1, 16'hffff, 1, 0));
    // allocate on an entry already present comes back untouched
    queue_request(make_request(REQ_ALLOC, 16'h0000, 1, 1, 1, 16'hffff, 0, 0));
    queue_request(make_request(REQ_ALLOC, 16'hffff, 1, 0, 0, 16'h0000, 1, 1));
    // named claims: next free frame, top frame, and a frame already in use
    queue_request(make_request(REQ_ALLOC_AT, 16'h0002, 0, 0, 0, 16'h0000, 1, 1));
    queue_request(make_request(REQ_ALLOC, 16'h0000, 0, 0, 0, 16'h0000, 0, 0));
    queue_request(make_request(REQ_ALLOC_AT, 16'hffff, 1, 1, 1, 16'hffff, 0, 0));
    queue_request(make_request(REQ_ALLOC_AT, 16'h0003, 0, 0, 0, 16'h0000, 0, 1));
    // free of frame zero changes nothing; free of frame 1 opens a hole
    queue_request(make_request(REQ_FREE, 16'hffff, 1, 1, 1, 16'h0000, 1, 1));
    queue_request(make_request(REQ_FREE, 16'h0000, 1, 0, 1, 16'h0001, 0, 0));
    queue_request(make_request(REQ_ALLOC, 16'h0000, 0, 0, 0, 16'h0000, 1, 1));
    // free of the top frame, then of a frame never claimed
    queue_request(make_request(REQ_FREE, 16'h0000, 0, 1, 0, 16'hffff, 0, 0));
    queue_request(make_request(REQ_FREE, 16'h0000, 1, 1, 0, 16'd40000, 1, 0));
    // undecoded type, all ones and all zeros
    queue_request(make_request(REQ_UNUSED, 16'hffff, 1, 1, 1, 16'hffff, 1, 1));
    queue_request(make_request(REQ_UNUSED, 16'h0000, 0, 0, 0, 16'h0000, 0, 0));

    // Random phases. Each waits for the previous one to drain before the limit moves.
    run_phase(CFG_W'(0), 12, 64, 1'b0);        // no word in range
    run_phase(CFG_W'(31), 12, 64, 1'b0);       // below one whole word
    run_phase(CFG_W'(64), 110, 80, 1'b0);      // two words: runs out, frees reopen
    run_phase(CFG_W'(96), 60, 128, 1'b1);      // back to back on both sides
    run_phase(CFG_W'(1024), 150, 1024, 1'b0);
    run_phase('1, 150, 512, 1'b0);             // above the map, search clamps
    run_phase(CFG_W'(65536), 160, 256, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (entries_due.size() != 0) begin
      $display("%0d entries never returned", entries_due.size());
    end
    $display("Ran %0d allocate, %0d allocate-at, %0d free and %0d undecoded requests",
             kind_count[REQ_ALLOC], kind_count[REQ_ALLOC_AT], kind_count[REQ_FREE],
             kind_count[REQ_UNUSED]);
    $display("over frame limits 0 to 131071: %0d out of frames, %0d already present, %0d errors",
             no_frame_count, present_count, errors);
    if (errors == 0 && entries_due.size() == 0) begin
      $display("** frame_bitmap_allocator: PASSED **");
    end else begin
      $display("** frame_bitmap_allocator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== frame_bitmap_allocator.f =====
rtl/fba_pkg.sv
rtl/frame_bitmap_allocator.sv
dv/frame_bitmap_allocator_test.sv
